// ===== src/seven_segment_number_display_core_assert.svh =====
// assertion macros used by the checker of the display core
`ifndef SEVEN_SEGMENT_NUMBER_DISPLAY_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_DISPLAY_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SSND_ASSERT_NOW(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ssnd check failed");

// next-cycle implication, disabled while reset is asserted
`define SSND_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ssnd check failed");

`endif

// ===== src/ssnd_pkg.sv =====
package ssnd_pkg;

	// function codes of an input beat
	localparam logic [1:0] FUNC_SIGNED = 2'd0;
	localparam logic [1:0] FUNC_FIXED  = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;

	// classified operations passed from front to back
	localparam logic [2:0] OP_SIGNED = 3'd0;
	localparam logic [2:0] OP_BLANK  = 3'd1;
	localparam logic [2:0] OP_FIXED  = 3'd2;
	localparam logic [2:0] OP_REJECT = 3'd3;
	localparam logic [2:0] OP_TICK   = 3'd4;
	localparam logic [2:0] OP_NOP    = 3'd5;

	// value limits
	localparam logic signed [16:0] SIGNED_MAX = 17'sd9999;
	localparam logic signed [16:0] SIGNED_MIN = -17'sd999;
	localparam logic [16:0]        FIXED_MAX  = 17'd9999;
	localparam logic [3:0]         POINT_MAX  = 4'd3;

	// reciprocal multipliers, exact for magnitudes up to 9999
	localparam logic [13:0] RECIP_10   = 14'd6554;
	localparam logic [13:0] RECIP_100  = 14'd5243;
	localparam logic [13:0] RECIP_1000 = 14'd8389;

	// segment bits
	localparam logic [7:0] SEG_MINUS = 8'h40;
	localparam logic [7:0] SEG_POINT = 8'h80;
	localparam logic [7:0] SEG_BLANK = 8'h00;

	// classified command
	typedef struct packed {
		logic [2:0]  op;
		logic        neg;
		logic [1:0]  fd;
		logic [13:0] mag;
		logic [9:0]  q10;
		logic [6:0]  q100;
		logic [3:0]  q1000;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic       status;
		logic [7:0] seg;
		logic [3:0] en;
	} res_t;

	// decimal digit to segments a..g
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		case (d)
			4'd0: g = 8'h3F;
			4'd1: g = 8'h06;
			4'd2: g = 8'h5B;
			4'd3: g = 8'h4F;
			4'd4: g = 8'h66;
			4'd5: g = 8'h6D;
			4'd6: g = 8'h7D;
			4'd7: g = 8'h07;
			4'd8: g = 8'h7F;
			4'd9: g = 8'h6F;
			default: g = SEG_BLANK;
		endcase
		return g;
	endfunction

endpackage

// ===== src/ssnd_front.sv =====
module ssnd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [1:0]           func,
	input  logic signed [16:0]   number,
	input  logic [3:0]           point_digits,
	output ssnd_pkg::cmd_t       cmd,
	output logic                 cmd_empty,
	input  logic                 cmd_pop
);
	import ssnd_pkg::*;

	cmd_t        entry;
	logic [16:0] mag_full;
	logic [27:0] p10;
	logic [27:0] p100;
	logic [27:0] p1000;
	logic        signed_ok;
	logic        fixed_ok;
	logic        push_ok;
	logic        pop_ok;
	cmd_t        cmd_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	// magnitude and decimal quotients by reciprocal multiplication
	always_comb begin
		mag_full  = (func == FUNC_SIGNED && number[16]) ? 17'(-number) : 17'(number);
		signed_ok = (number <= SIGNED_MAX) && (number >= SIGNED_MIN);
		fixed_ok  = ($unsigned(number) <= FIXED_MAX) && (point_digits <= POINT_MAX);
		p10       = 28'(mag_full[13:0]) * 28'(RECIP_10);
		p100      = 28'(mag_full[13:0]) * 28'(RECIP_100);
		p1000     = 28'(mag_full[13:0]) * 28'(RECIP_1000);
	end

	// classify the beat
	always_comb begin
		entry.neg   = number[16];
		entry.fd    = point_digits[1:0];
		entry.mag   = mag_full[13:0];
		entry.q10   = p10[25:16];
		entry.q100  = p100[25:19];
		entry.q1000 = p1000[26:23];
		case (func)
			FUNC_SIGNED: entry.op = signed_ok ? OP_SIGNED : OP_BLANK;
			FUNC_FIXED:  entry.op = fixed_ok ? OP_FIXED : OP_REJECT;
			FUNC_TICK:   entry.op = OP_TICK;
			default:     entry.op = OP_NOP;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign cmd_empty = (cnt_q == 2'd0);
	assign push_ok   = push && !full;
	assign pop_ok    = cmd_pop && !cmd_empty;
	assign cmd       = cmd_q[rd_ptr_q];

	// command queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) wr_ptr_q <= !wr_ptr_q;
			if (pop_ok) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push_ok) - 2'(pop_ok);
		end
	end

	// command queue storage
	always_ff @(posedge clk) begin
		if (push_ok) cmd_q[wr_ptr_q] <= entry;
	end

endmodule

// ===== src/ssnd_back.sv =====
module ssnd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  ssnd_pkg::cmd_t cmd,
	input  logic           cmd_empty,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output logic           status,
	output logic [7:0]     segment_drive,
	output logic [3:0]     digit_enable
);
	import ssnd_pkg::*;

	logic [7:0] patterns_q [4];
	logic [7:0] pat_d [4];
	logic [1:0] scan_q;
	logic [1:0] scan_d;
	logic [3:0] d0;
	logic [3:0] d1;
	logic [3:0] d2;
	res_t       res_d;
	res_t       res_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       res_full;
	logic       pop_ok;

	assign res_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign cmd_pop  = !cmd_empty && !res_full;
	assign pop_ok   = pop && !empty;

	// remainders from the quotients
	always_comb begin
		d0 = 4'(cmd.mag - 14'(cmd.q10) * 14'd10);
		d1 = 4'(cmd.q10 - 10'(cmd.q100) * 10'd10);
		d2 = 4'(cmd.q100 - 7'(cmd.q1000) * 7'd10);
	end

	// apply the command to the digit patterns and form the result
	always_comb begin
		pat_d  = patterns_q;
		scan_d = scan_q;
		res_d  = '0;
		case (cmd.op)
			OP_SIGNED: begin
				pat_d[0] = glyph(d0);
				pat_d[1] = (cmd.q10 != '0) ? glyph(d1) : SEG_BLANK;
				pat_d[2] = (cmd.q100 != '0) ? glyph(d2) : SEG_BLANK;
				pat_d[3] = cmd.neg ? SEG_MINUS
					: ((cmd.q1000 != '0) ? glyph(cmd.q1000) : SEG_BLANK);
			end
			OP_BLANK: begin
				for (int i = 0; i < 4; i++) pat_d[i] = SEG_BLANK;
				res_d.status = 1'b1;
			end
			OP_FIXED: begin
				pat_d[0] = glyph(d0);
				pat_d[1] = (cmd.q10 != '0) ? glyph(d1)
					: ((cmd.fd >= 2'd1) ? glyph(4'd0) : SEG_BLANK);
				pat_d[2] = (cmd.q100 != '0) ? glyph(d2)
					: ((cmd.fd >= 2'd2) ? glyph(4'd0) : SEG_BLANK);
				pat_d[3] = (cmd.q1000 != '0) ? glyph(cmd.q1000)
					: ((cmd.fd >= 2'd3) ? glyph(4'd0) : SEG_BLANK);
				if (cmd.fd != 2'd0) pat_d[cmd.fd] = pat_d[cmd.fd] | SEG_POINT;
			end
			OP_REJECT: begin
				res_d.status = 1'b1;
			end
			OP_TICK: begin
				res_d.seg = patterns_q[scan_q];
				res_d.en  = 4'(4'd1 << scan_q);
				scan_d    = scan_q + 2'd1;
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// display state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) patterns_q[i] <= SEG_BLANK;
			scan_q <= 2'd0;
		end else if (cmd_pop) begin
			patterns_q <= pat_d;
			scan_q     <= scan_d;
		end
	end

	// result queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (cmd_pop) wr_ptr_q <= !wr_ptr_q;
			if (pop_ok) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(cmd_pop) - 2'(pop_ok);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (cmd_pop) res_q[wr_ptr_q] <= res_d;
	end

	// oldest result beat on the ports
	assign status        = res_q[rd_ptr_q].status;
	assign segment_drive = res_q[rd_ptr_q].seg;
	assign digit_enable  = res_q[rd_ptr_q].en;

endmodule

// ===== src/seven_segment_number_display_core.sv =====
// an accepted input beat is registered in the command queue, and its result in the result queue once it has room
// throughput: one beat per cycle while results are popped; the front multiplies and the back decodes combinationally
// two-entry queues sit between front and back and on the result side
// reset (arst_n low): queues empty, all digit patterns blank, scan at digit 0
module seven_segment_number_display_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [1:0]          func,
	input  logic signed [16:0]  number,
	input  logic [3:0]          point_digits,
	output logic                empty,
	input  logic                pop,
	output logic                status,
	output logic [7:0]          segment_drive,
	output logic [3:0]          digit_enable
);
	import ssnd_pkg::*;

	cmd_t cmd;
	logic cmd_empty;
	logic cmd_pop;

	// classify and divide
	ssnd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.func         (func),
		.number       (number),
		.point_digits (point_digits),
		.cmd          (cmd),
		.cmd_empty    (cmd_empty),
		.cmd_pop      (cmd_pop)
	);

	// update patterns and scan
	ssnd_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cmd_empty     (cmd_empty),
		.cmd_pop       (cmd_pop),
		.empty         (empty),
		.pop           (pop),
		.status        (status),
		.segment_drive (segment_drive),
		.digit_enable  (digit_enable)
	);

endmodule

// ===== src/ssnd_checker.sv =====
`include "seven_segment_number_display_core_assert.svh"

module ssnd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input logic               status,
	input logic [7:0]         segment_drive,
	input logic [3:0]         digit_enable
);

	// a lit digit is exactly one digit
	`SSND_ASSERT_NOW(a_enable_onehot, clk, arst_n, !empty && digit_enable != 4'd0, $onehot(digit_enable))

	// segments only come with a digit enable
	`SSND_ASSERT_NOW(a_seg_needs_enable, clk, arst_n, !empty && segment_drive != 8'd0, digit_enable != 4'd0)

	// an error beat drives nothing
	`SSND_ASSERT_NOW(a_status_quiet, clk, arst_n, !empty && status, digit_enable == 4'd0 && segment_drive == 8'd0)

	// a waiting beat is not dropped
	`SSND_ASSERT_NEXT(a_result_held, clk, arst_n, !empty && !pop, !empty)

endmodule

bind seven_segment_number_display_core ssnd_checker u_ssnd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.empty         (empty),
	.pop           (pop),
	.status        (status),
	.segment_drive (segment_drive),
	.digit_enable  (digit_enable)
);

// ===== dv/seven_segment_number_display_core_test.sv =====
`timescale 1ns / 100ps

module seven_segment_number_display_core_test;
	import ssnd_pkg::*;

	localparam int CLK_PERIOD = 12;
	localparam int RANDOM_BEATS = 1250;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// the one function code the block leaves unused
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	// segments a..g for the decimal digits
	localparam logic [7:0] DIGIT_SEGS [10] = '{
		8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic [1:0] func = FUNC_SIGNED;
	logic signed [16:0] number = '0;
	logic [3:0] point_digits = '0;
	logic pop = 1'b0;
	logic full;
	logic empty;
	logic status;
	logic [7:0] segment_drive;
	logic [3:0] digit_enable;

	bit hold_off_request = 1'b0;
	bit send_quiet = 1'b0;
	bit take_quiet = 1'b0;
	int cycles = 0;

	seven_segment_number_display_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.func(func),
		.number(number),
		.point_digits(point_digits),
		.empty(empty),
		.pop(pop),
		.status(status),
		.segment_drive(segment_drive),
		.digit_enable(digit_enable)
	);

	// shadow of the digit patterns and scan position, with the results still owed
	class display_tracker;
		logic [7:0] patterns [4];
		logic [1:0] scan;
		res_t owed_results [$];
		int errors;

		function new();
			foreach (patterns[i]) patterns[i] = SEG_BLANK;
			scan = 2'd0;
			errors = 0;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// update the shadow for one accepted input beat and queue its result
		function void note_beat(logic [1:0] f, logic [16:0] raw, logic [3:0] pd);
			res_t r;
			int v;
			int mag;
			bit neg;
			r = '0;
			case (f)
				FUNC_SIGNED: begin
					v = int'($signed(raw));
					if (v > 9999 || v < -999) begin
						foreach (patterns[i]) patterns[i] = SEG_BLANK;
						r.status = 1'b1;
					end else begin
						neg = v < 0;
						mag = neg ? -v : v;
						patterns[0] = DIGIT_SEGS[mag % 10];
						for (int i = 1; i < 4; i++) begin
							mag = mag / 10;
							if (i == 3 && neg)
								patterns[i] = SEG_MINUS;
							else
								patterns[i] = (mag != 0) ? DIGIT_SEGS[mag % 10] : SEG_BLANK;
						end
					end
				end
				FUNC_FIXED: begin
					mag = int'(raw);
					if (mag > 9999 || pd > 4'd3) begin
						r.status = 1'b1;
					end else begin
						patterns[0] = DIGIT_SEGS[mag % 10];
						for (int i = 1; i < 4; i++) begin
							mag = mag / 10;
							// zeros are padded up to the point
							if (mag != 0)
								patterns[i] = DIGIT_SEGS[mag % 10];
							else
								patterns[i] = (pd >= i) ? DIGIT_SEGS[0] : SEG_BLANK;
						end
						if (pd != 4'd0)
							patterns[pd[1:0]] = patterns[pd[1:0]] | SEG_POINT;
					end
				end
				FUNC_TICK: begin
					r.seg = patterns[scan];
					r.en = 4'b0001 << scan;
					scan = scan + 2'd1;
				end
				default: begin
				end
			endcase
			owed_results.push_back(r);
		endfunction

		// compare one accepted result beat with the oldest owed result
		function void check_beat(logic st, logic [7:0] seg, logic [3:0] en);
			res_t want;
			if (owed_results.size() == 0) begin
				$display("%0t: result beat with nothing owed: status %0b seg %02h enable %04b",
					$time, st, seg, en);
				errors++;
				return;
			end
			want = owed_results.pop_front();
			if (st !== want.status) begin
				$display("%0t: status expected %0b actual %0b", $time, want.status, st);
				errors++;
			end
			if (seg !== want.seg) begin
				$display("%0t: segment_drive expected %02h actual %02h", $time, want.seg, seg);
				errors++;
			end
			if (en !== want.en) begin
				$display("%0t: digit_enable expected %04b actual %04b", $time, want.en, en);
				errors++;
			end
		endfunction
	endclass

	display_tracker board = new();

	// clock
	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("seven_segment_number_display_core_test: errors");
			$finish;
		end
	end

	// idle length for one beat, with calm stretches where nothing idles
	function automatic int draw_gap(ref bit quiet);
		if ($urandom_range(0, 39) == 0)
			quiet = !quiet;
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// offer one input beat and wait until it is taken
	task automatic send_beat(input logic [1:0] f, input logic [16:0] raw, input logic [3:0] pd);
		int gap;
		gap = hold_off_request ? 0 : draw_gap(send_quiet);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		func <= f;
		number <= raw;
		point_digits <= pd;
		do @(posedge clk); while (full);
		board.note_beat(f, raw, pd);
	endtask

	// stop offering until every owed result has come back
	task automatic wait_for_drain();
		push <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
	endtask

	// take result beats forever, with random stalls and one long hold-off on request
	task automatic run_receiver();
		int gap;
		forever begin
			if (hold_off_request) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_request = 1'b0;
			end else begin
				gap = draw_gap(take_quiet);
				if (gap > 0) begin
					pop <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			board.check_beat(status, segment_drive, digit_enable);
		end
	endtask

	// one random beat, weighted toward valid updates and scan ticks
	task automatic send_random_beat();
		int pick;
		int limit;
		int v;
		logic [16:0] raw;
		logic [3:0] pd;
		pick = $urandom_range(0, 99);
		raw = 17'($urandom);
		pd = 4'($urandom_range(0, 15));
		if (pick < 35) begin
			send_beat(FUNC_TICK, raw, pd);
		end else if (pick < 60) begin
			if ($urandom_range(0, 7) != 0) begin
				case ($urandom_range(0, 3))
					0: limit = 9;
					1: limit = 99;
					2: limit = 999;
					default: limit = 9999;
				endcase
				v = $urandom_range(0, limit);
				if ($urandom_range(0, 3) == 0 && v <= 999)
					v = -v;
				raw = 17'(v);
			end
			send_beat(FUNC_SIGNED, raw, pd);
		end else if (pick < 90) begin
			if ($urandom_range(0, 7) != 0) begin
				case ($urandom_range(0, 3))
					0: limit = 9;
					1: limit = 99;
					2: limit = 999;
					default: limit = 9999;
				endcase
				raw = 17'($urandom_range(0, limit));
				pd = 4'($urandom_range(0, 3));
			end
			send_beat(FUNC_FIXED, raw, pd);
		end else if (pick < 97) begin
			send_beat(2'($urandom_range(0, 3)), raw, pd);
		end else begin
			send_beat(FUNC_UNUSED, raw, pd);
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			run_receiver();
		join_none

		// directed: extremes, blanking, minus sign, padding and rejects
		send_beat(FUNC_SIGNED, 17'd9999, 4'd0);
		repeat (4) send_beat(FUNC_TICK, 17'd0, 4'd0);
		send_beat(FUNC_SIGNED, 17'(-999), 4'd0);
		repeat (4) send_beat(FUNC_TICK, 17'h1FFFF, 4'hF);
		send_beat(FUNC_SIGNED, 17'(-5), 4'd0);
		send_beat(FUNC_FIXED, 17'd1234, 4'd3);
		repeat (4) send_beat(FUNC_TICK, 17'd0, 4'd0);
		send_beat(FUNC_FIXED, 17'd7, 4'd3);
		send_beat(FUNC_FIXED, 17'd0, 4'd0);
		send_beat(FUNC_FIXED, 17'd9999, 4'd2);
		send_beat(FUNC_FIXED, 17'd10000, 4'd1);
		send_beat(FUNC_FIXED, 17'd5, 4'd4);
		send_beat(FUNC_FIXED, 17'h0FFFF, 4'hF);
		send_beat(FUNC_SIGNED, 17'd10000, 4'd0);
		send_beat(FUNC_SIGNED, 17'(-1000), 4'd0);
		send_beat(FUNC_UNUSED, 17'h1FFFF, 4'hF);
		wait_for_drain();

		// random beats with one long receiver hold-off and one full drain
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if (i == RANDOM_BEATS / 3)
				hold_off_request = 1'b1;
			if (i == (2 * RANDOM_BEATS) / 3)
				wait_for_drain();
			send_random_beat();
		end
		push <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("seven_segment_number_display_core_test: clean");
		else
			$display("seven_segment_number_display_core_test: errors");
		$finish;
	end

endmodule
